FILE: design/dhc_pkg.sv
`timescale 1ns / 1ps

package dhc_pkg;

   // Keypad codes (ASCII)
   localparam logic [7:0] KEY_CANCEL     = 8'h58;  // 'X'
   localparam logic [7:0] KEY_ENTER      = 8'h45;  // 'E'
   localparam logic [7:0] KEY_SLOT_BASE  = 8'h40;  // '@', one below the first slot key
   localparam logic [7:0] KEY_SLOT_FIRST = 8'h41;  // 'A'
   localparam logic [7:0] KEY_SLOT_LAST  = 8'h44;  // 'D'
   localparam logic [7:0] KEY_DIGIT_0    = 8'h30;
   localparam logic [7:0] KEY_DIGIT_9    = 8'h39;

   // Key status codes
   localparam logic [2:0] STATUS_NONE        = 3'd0;
   localparam logic [2:0] STATUS_TARGET_SET  = 3'd1;
   localparam logic [2:0] STATUS_VALUE_RANGE = 3'd2;
   localparam logic [2:0] STATUS_SLOT_EMPTY  = 3'd3;
   localparam logic [2:0] STATUS_SLOT_RANGE  = 3'd4;
   localparam logic [2:0] STATUS_RECORDED    = 3'd5;
   localparam logic [2:0] STATUS_CANCELLED   = 3'd6;
   localparam logic [2:0] STATUS_DIGIT       = 3'd7;

   // Motor direction codes
   localparam logic [1:0] DIR_IDLE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_MIN_HEIGHT   = 2'd0;
   localparam logic [1:0] CSR_MAX_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_PRESET_COUNT = 2'd2;

   localparam logic [7:0] POWER_STEP     = 8'd51;
   localparam logic [2:0] POWER_BREAK_CM = 3'd5;

   localparam logic [7:0] RESET_MIN_HEIGHT   = 8'd0;
   localparam logic [7:0] RESET_MAX_HEIGHT   = 8'd255;
   localparam logic [2:0] RESET_PRESET_COUNT = 3'd4;

   typedef struct packed {
      logic        key_valid;
      logic [7:0]  key_code;
      logic [11:0] height_sample;
   } req_item_type;

   typedef struct packed {
      logic [7:0] motor_power;
      logic [1:0] motor_direction;
      logic       moving;
      logic [7:0] target_height;
      logic [2:0] key_status;
      logic       arrived;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] reg_index;
      logic [7:0] write_data;
   } csr_item_type;

endpackage

FILE: design/dhc_if.sv
`timescale 1ns / 1ps

interface dhc_req_if;
   logic                  valid;
   logic                  ready;
   dhc_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dhc_rsp_if;
   logic                  valid;
   logic                  ready;
   dhc_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dhc_csr_if;
   logic                  valid;
   logic                  ready;
   dhc_pkg::csr_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/desk_height_controller_core.sv
`timescale 1ns / 1ps

// Channel    Dir  Handshake          Word
// req_chan   in   valid/ready        key_valid, key_code, height_sample
// rsp_chan   out  valid/ready        motor_power, motor_direction, moving,
//                                    target_height, key_status, arrived
// csr_chan   in   valid/ready (=1)   reg_index, write_data
//
// One word per cycle sustained while rsp_chan is not stalled; an accepted request
// word passes the input register, then the result register, to reach rsp_chan.
// Key handling and motor update run in one pass from the input register, so
// the controller state is ready for the next word in the following cycle.
// Synchronous active-high reset clears state, presets and registers to defaults.
// A stalled rsp_chan holds the result; one more word waits in the input register.
module desk_height_controller_core #(
   parameter int PRESET_SLOTS     = 4,
   parameter int HEIGHT_FRAC_BITS = 4
) (
   input  logic      clock,
   input  logic      reset,
   dhc_req_if.sink   req_chan,
   dhc_rsp_if.source rsp_chan,
   dhc_csr_if.sink   csr_chan
);
   import dhc_pkg::*;

   localparam int SLOT_IDX_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
   localparam int GOAL_W     = 8 + HEIGHT_FRAC_BITS;
   localparam int DIST_W     = (GOAL_W > 12) ? GOAL_W : 12;
   localparam logic [2:0] SLOT_LIMIT = 3'(PRESET_SLOTS);
   localparam logic [DIST_W-1:0] NEAR_LIMIT = DIST_W'(1) << (HEIGHT_FRAC_BITS - 1);

   // configuration
   logic [7:0] min_height_ff;
   logic [7:0] max_height_ff;
   logic [2:0] preset_count_ff;

   // controller state
   logic       moving_ff, moving_in;
   logic [7:0] target_ff, target_in;
   logic [1:0] dir_ff, dir_in;
   logic [7:0] entry_value_ff, entry_value_in;
   logic       entry_present_ff, entry_present_in;
   logic       entry_ended_ff, entry_ended_in;
   logic [7:0] store_ff [PRESET_SLOTS];

   // pipeline registers
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic advance;

   // key decode and motor pass
   logic [7:0]            key;
   logic [2:0]            slot_num;
   logic [SLOT_IDX_W-1:0] slot_idx;
   logic [7:0]            stored;
   logic                  store_we;
   logic [2:0]            status;
   logic                  arrived;
   logic [7:0]            power;
   logic [DIST_W-1:0]     goal, sample, span, cm;
   logic [2:0]            cm_cap;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_item_ff;

   assign key      = in_item_ff.key_code;
   assign slot_num = 3'(key - KEY_SLOT_BASE);
   assign slot_idx = SLOT_IDX_W'(slot_num - 3'd1);
   assign stored   = store_ff[slot_idx];

   always_comb begin
      status           = STATUS_NONE;
      store_we         = 1'b0;
      moving_in        = moving_ff;
      target_in        = target_ff;
      dir_in           = dir_ff;
      entry_value_in   = entry_value_ff;
      entry_present_in = entry_present_ff;
      entry_ended_in   = entry_ended_ff;
      arrived          = 1'b0;
      power            = 8'd0;

      if (in_item_ff.key_valid) begin
         if (key == KEY_CANCEL) begin
            moving_in        = 1'b0;
            dir_in           = DIR_IDLE;
            entry_value_in   = 8'd0;
            entry_present_in = 1'b0;
            entry_ended_in   = 1'b0;
            status           = STATUS_CANCELLED;
         end else if (key >= KEY_SLOT_FIRST && key <= KEY_SLOT_LAST) begin
            if (slot_num > preset_count_ff || slot_num > SLOT_LIMIT) begin
               status = STATUS_SLOT_RANGE;
            end else if (!entry_present_ff) begin
               if (stored == 8'd0) begin
                  status = STATUS_SLOT_EMPTY;
               end else if (stored < min_height_ff || stored > max_height_ff) begin
                  status = STATUS_VALUE_RANGE;
               end else begin
                  target_in = stored;
                  moving_in = 1'b1;
                  status    = STATUS_TARGET_SET;
               end
            end else if (entry_value_ff < min_height_ff || entry_value_ff > max_height_ff) begin
               status = STATUS_VALUE_RANGE;
            end else begin
               store_we = 1'b1;
               status   = STATUS_RECORDED;
            end
            entry_value_in   = 8'd0;
            entry_present_in = 1'b0;
            entry_ended_in   = 1'b0;
         end else if (key == KEY_ENTER) begin
            if (entry_present_ff) begin
               if (entry_value_ff < min_height_ff || entry_value_ff > max_height_ff) begin
                  status = STATUS_VALUE_RANGE;
               end else begin
                  target_in = entry_value_ff;
                  moving_in = 1'b1;
                  status    = STATUS_TARGET_SET;
               end
               entry_value_in   = 8'd0;
               entry_present_in = 1'b0;
               entry_ended_in   = 1'b0;
            end
         end else begin
            entry_present_in = 1'b1;
            if (!entry_ended_ff) begin
               if (key >= KEY_DIGIT_0 && key <= KEY_DIGIT_9) begin
                  // value * 10 + digit, wrapping at 256
                  entry_value_in = 8'((entry_value_ff << 3) + (entry_value_ff << 1)
                                      + 8'(key - KEY_DIGIT_0));
               end else begin
                  entry_ended_in = 1'b1;
               end
            end
            status = STATUS_DIGIT;
         end
      end

      goal   = DIST_W'(target_in) << HEIGHT_FRAC_BITS;
      sample = DIST_W'(in_item_ff.height_sample);
      span   = (goal >= sample) ? goal - sample : sample - goal;
      cm     = span >> HEIGHT_FRAC_BITS;
      cm_cap = (cm > DIST_W'(POWER_BREAK_CM)) ? POWER_BREAK_CM : cm[2:0];

      if (moving_in) begin
         if (span < NEAR_LIMIT) begin
            moving_in = 1'b0;
            dir_in    = DIR_IDLE;
            arrived   = 1'b1;
         end else begin
            dir_in = (sample <= goal) ? DIR_UP : DIR_DOWN;
            power  = 8'({5'd0, cm_cap} * POWER_STEP);
         end
      end

      rsp_item_in.motor_power     = power;
      rsp_item_in.motor_direction = dir_in;
      rsp_item_in.moving          = moving_in;
      rsp_item_in.target_height   = target_in;
      rsp_item_in.key_status      = status;
      rsp_item_in.arrived         = arrived;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff   <= RESET_MIN_HEIGHT;
         max_height_ff   <= RESET_MAX_HEIGHT;
         preset_count_ff <= RESET_PRESET_COUNT;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.data.reg_index)
            CSR_MIN_HEIGHT:   min_height_ff   <= csr_chan.data.write_data;
            CSR_MAX_HEIGHT:   max_height_ff   <= csr_chan.data.write_data;
            CSR_PRESET_COUNT: preset_count_ff <= csr_chan.data.write_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff        <= 1'b0;
         target_ff        <= 8'd0;
         dir_ff           <= DIR_IDLE;
         entry_value_ff   <= 8'd0;
         entry_present_ff <= 1'b0;
         entry_ended_ff   <= 1'b0;
         for (int i = 0; i < PRESET_SLOTS; i++) begin
            store_ff[i] <= 8'd0;
         end
      end else if (advance) begin
         moving_ff        <= moving_in;
         target_ff        <= target_in;
         dir_ff           <= dir_in;
         entry_value_ff   <= entry_value_in;
         entry_present_ff <= entry_present_in;
         entry_ended_ff   <= entry_ended_in;
         if (store_we) begin
            store_ff[slot_idx] <= entry_value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         // hold the result until taken
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff <= req_chan.data;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_advance_loads_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_item_ff == $past(rsp_item_in))
      else $error("result register did not load on advance");

   a_power_needs_motion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.motor_power != 8'd0 |->
         rsp_item_ff.moving && rsp_item_ff.motor_direction != DIR_IDLE)
      else $error("motor driven while not moving");

   a_arrival_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.arrived |->
         !rsp_item_ff.moving && rsp_item_ff.motor_power == 8'd0
         && rsp_item_ff.motor_direction == DIR_IDLE)
      else $error("arrival did not stop the motor");

   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(moving_ff) && $stable(target_ff) && $stable(entry_value_ff))
      else $error("controller state changed without an accepted word");
`endif

endmodule
